>>> rtl/core/ctd_pkg.sv
// Shared types, codes and helper functions for the chunked transfer decoder.
package ctd_pkg;

   // Beat received on the request channel.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   // Beat sent on the response channel.
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       chunk_last;
      logic [2:0] status;
   } rsp_type;

   typedef enum logic [6:0] {
      PH_DIGITS   = 7'b0000001,
      PH_EXT      = 7'b0000010,
      PH_SIZE_LF  = 7'b0000100,
      PH_DATA     = 7'b0001000,
      PH_TRAIL_CR = 7'b0010000,
      PH_TRAIL_LF = 7'b0100000,
      PH_HALT     = 7'b1000000
   } phase_type;

   // Control state that travels between the top level and the step logic.
   typedef struct packed {
      phase_type phase;
      logic      final_chunk;
   } ctrl_type;

   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_DONE     = 3'd1;
   localparam logic [2:0] ST_BAD_END  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_HALTED   = 3'd4;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Flag for a byte that is not a hex digit.
   localparam logic [4:0] HEX_NONE = 5'd16;

   // Returns the digit value 0 to 15, or HEX_NONE for a non-hex byte.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      begin
         t = 8'd0;
         hex_value = HEX_NONE;
         case (c) inside
            [8'h30:8'h39]: begin
               t = c - 8'h30;
               hex_value = t[4:0];
            end
            [8'h41:8'h46]: begin
               t = c - 8'h37;
               hex_value = t[4:0];
            end
            [8'h61:8'h66]: begin
               t = c - 8'h57;
               hex_value = t[4:0];
            end
            default: hex_value = HEX_NONE;
         endcase
      end
   endfunction

endpackage

>>> rtl/core/ctd_step.sv
// Next-state and response logic for one byte of the chunked transfer decoder.
module ctd_step #(
   parameter int LEN_BITS = 32
) (
   input  ctd_pkg::req_type        req,
   input  ctd_pkg::ctrl_type       ctrl_cur,
   input  logic [LEN_BITS-1:0]     remaining_cur,
   output ctd_pkg::ctrl_type       ctrl_nxt,
   output logic [LEN_BITS-1:0]     remaining_nxt,
   output ctd_pkg::rsp_type        rsp
);

   ctd_pkg::ctrl_type   ctrl_eff;
   logic [LEN_BITS-1:0] rem_eff;
   logic [LEN_BITS-1:0] rem_dec;
   logic [LEN_BITS-1:0] rem_shift;
   logic [4:0]          digit;
   logic [7:0]          c;

   assign c = req.in_byte;

   // Restart clears all progress before this byte is handled.
   always_comb begin
      if (req.restart) begin
         ctrl_eff.phase       = ctd_pkg::PH_DIGITS;
         ctrl_eff.final_chunk = 1'b0;
         rem_eff              = '0;
      end else begin
         ctrl_eff = ctrl_cur;
         rem_eff  = remaining_cur;
      end
   end

   assign digit     = ctd_pkg::hex_value(c);
   assign rem_dec   = rem_eff - {{(LEN_BITS-1){1'b0}}, 1'b1};
   assign rem_shift = {rem_eff[LEN_BITS-5:0], digit[3:0]};

   always_comb begin
      ctrl_nxt      = ctrl_eff;
      remaining_nxt = rem_eff;
      rsp           = '0;
      rsp.status    = ctd_pkg::ST_BUSY;
      case (ctrl_eff.phase)
         ctd_pkg::PH_DIGITS: begin
            if (c == ctd_pkg::CH_CR) begin
               ctrl_nxt.phase = ctd_pkg::PH_SIZE_LF;
            end else if (digit == ctd_pkg::HEX_NONE) begin
               ctrl_nxt.phase = ctd_pkg::PH_EXT;
            end else if (rem_eff[LEN_BITS-1 -: 4] != 4'd0) begin
               // Another digit would not fit in the length register.
               rsp.status     = ctd_pkg::ST_OVERFLOW;
               ctrl_nxt.phase = ctd_pkg::PH_HALT;
            end else begin
               remaining_nxt = rem_shift;
            end
         end
         ctd_pkg::PH_EXT: begin
            if (c == ctd_pkg::CH_CR) begin
               ctrl_nxt.phase = ctd_pkg::PH_SIZE_LF;
            end
         end
         ctd_pkg::PH_SIZE_LF: begin
            if (c != ctd_pkg::CH_LF) begin
               rsp.status     = ctd_pkg::ST_BAD_END;
               ctrl_nxt.phase = ctd_pkg::PH_HALT;
            end else if (rem_eff == '0) begin
               ctrl_nxt.final_chunk = 1'b1;
               ctrl_nxt.phase       = ctd_pkg::PH_TRAIL_CR;
            end else begin
               ctrl_nxt.phase = ctd_pkg::PH_DATA;
            end
         end
         ctd_pkg::PH_DATA: begin
            rsp.payload_valid = 1'b1;
            rsp.payload_byte  = c;
            remaining_nxt     = rem_dec;
            if (rem_dec == '0) begin
               rsp.chunk_last = 1'b1;
               ctrl_nxt.phase = ctd_pkg::PH_TRAIL_CR;
            end
         end
         ctd_pkg::PH_TRAIL_CR: begin
            if (c != ctd_pkg::CH_CR) begin
               rsp.status     = ctd_pkg::ST_BAD_END;
               ctrl_nxt.phase = ctd_pkg::PH_HALT;
            end else begin
               ctrl_nxt.phase = ctd_pkg::PH_TRAIL_LF;
            end
         end
         ctd_pkg::PH_TRAIL_LF: begin
            if (c != ctd_pkg::CH_LF) begin
               rsp.status     = ctd_pkg::ST_BAD_END;
               ctrl_nxt.phase = ctd_pkg::PH_HALT;
            end else begin
               if (ctrl_eff.final_chunk) begin
                  rsp.status = ctd_pkg::ST_DONE;
               end
               ctrl_nxt.phase       = ctd_pkg::PH_DIGITS;
               ctrl_nxt.final_chunk = 1'b0;
               remaining_nxt        = '0;
            end
         end
         default: begin
            rsp.status     = ctd_pkg::ST_HALTED;
            ctrl_nxt.phase = ctd_pkg::PH_HALT;
         end
      endcase
   end

endmodule

>>> rtl/core/chunked_transfer_decoder.sv
// An accepted beat is held in the input register and moves to the output register on rsp_data once that is free.
// Throughput: one beat per cycle unless rsp_stall holds the output; the phase, length
// and output register update together, so consecutive bytes need no gap.
// A stalled response backs up into the input register and then into req_stall.
// Reset clears both valid flags, the phase to size digits, the length and the
// final-chunk flag.
module chunked_transfer_decoder #(
   parameter int LEN_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctd_pkg::rsp_type  rsp_data
);

   logic                s1_valid_ff, s1_valid_in;
   ctd_pkg::req_type    s1_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   ctd_pkg::rsp_type    rsp_data_ff;
   ctd_pkg::ctrl_type   ctrl_ff, ctrl_in;
   logic [LEN_BITS-1:0] remaining_ff, remaining_in;
   ctd_pkg::rsp_type    step_rsp;
   logic                out_free;
   logic                advance;
   logic                accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   ctd_step #(.LEN_BITS(LEN_BITS)) u_step (
      .req           (s1_data_ff),
      .ctrl_cur      (ctrl_ff),
      .remaining_cur (remaining_ff),
      .ctrl_nxt      (ctrl_in),
      .remaining_nxt (remaining_in),
      .rsp           (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         ctrl_ff.phase        <= ctd_pkg::PH_DIGITS;
         ctrl_ff.final_chunk  <= 1'b0;
         remaining_ff         <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctrl_ff      <= ctrl_in;
            remaining_ff <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Payload beats never carry a completion or error status.
   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.payload_valid |-> rsp_data_ff.status == ctd_pkg::ST_BUSY)
      else $error("payload beat with non-busy status");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.chunk_last |-> rsp_data_ff.payload_valid)
      else $error("chunk_last without payload");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.payload_valid |-> rsp_data_ff.payload_byte == 8'd0)
      else $error("payload byte not zero on a framing beat");

   // After a beat leaves the data phase with chunk_last, the phase must be trailer CR.
   a_last_to_trailer: assert property (@(posedge clock) disable iff (reset)
      advance && step_rsp.chunk_last |=> ctrl_ff.phase == ctd_pkg::PH_TRAIL_CR)
      else $error("chunk end did not move to trailer");

   a_stall_needs_data: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free pipeline");

endmodule
